@@ design/sdns_pkg.sv @@
// ----------------------------------------------------------------------------
// sdns_pkg
// Types and constants shared by the support domain neighbour search unit.
// ----------------------------------------------------------------------------
package sdns_pkg;

  localparam int POS_W     = 32;
  localparam int EXT_W     = 31;
  localparam int MET_W     = 32;
  localparam int IDX_W     = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int ACC_W     = 98;
  localparam int STEP_W    = 4;

  // support shapes
  localparam logic [1:0] SHAPE_RADIAL  = 2'd0;
  localparam logic [1:0] SHAPE_BOX     = 2'd1;
  localparam logic [1:0] SHAPE_ELLIPSE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'b1;

  // actions
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // evaluation steps
  localparam logic [STEP_W-1:0] STEP_SQ0    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_SQ1    = 4'd1;
  localparam logic [STEP_W-1:0] STEP_SQ2    = 4'd2;
  localparam logic [STEP_W-1:0] STEP_TERM0  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_TERM7  = 4'd10;
  localparam logic [STEP_W-1:0] STEP_RAD_OK = 4'd3;
  localparam logic [STEP_W-1:0] STEP_ELL_OK = 4'd12;

  // 1.0 in Q50.48
  localparam logic [ACC_W-1:0] ONE_Q48 = ACC_W'(1) << 48;

  typedef struct packed {
    logic                     action;
    logic [IDX_W-1:0]         entry_index;
    logic signed [POS_W-1:0]  point_x;
    logic signed [POS_W-1:0]  point_y;
    logic [EXT_W-1:0]         extent_x;
    logic [EXT_W-1:0]         extent_y;
    logic signed [MET_W-1:0]  metric_11;
    logic signed [MET_W-1:0]  metric_12;
    logic signed [MET_W-1:0]  metric_21;
    logic signed [MET_W-1:0]  metric_22;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] neighbour_index;
    logic             found;
    logic             last;
  } result_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [EXT_W-1:0]        ext_x;
    logic [EXT_W-1:0]        ext_y;
    logic signed [MET_W-1:0] m11;
    logic signed [MET_W-1:0] m12;
    logic signed [MET_W-1:0] m21;
    logic signed [MET_W-1:0] m22;
  } node_t;

  typedef struct packed {
    logic done;
    logic hit;
  } eval_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_START,
    S_WAIT,
    S_FLUSH
  } scan_state_t;

endpackage

@@ design/sdns_ram.sv @@
// ----------------------------------------------------------------------------
// sdns_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sdns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/sdns_eval.sv @@
// ----------------------------------------------------------------------------
// sdns_eval
// Support test of one node against the query point. Box test by direct compare,
// radial and elliptical tests stepped through one 32x32 multiplier.
// ----------------------------------------------------------------------------
module sdns_eval (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [1:0]                   shape,
  input  logic signed [31:0]           qx,
  input  logic signed [31:0]           qy,
  input  sdns_pkg::node_t              node,
  output sdns_pkg::eval_status_t       status
);
  import sdns_pkg::*;

  logic signed [32:0] dx, dy;
  logic [32:0]        ndx, ndy;
  logic [31:0]        adx, ady;

  logic [31:0]              ax, ay;
  logic                     sgn_x, sgn_y;
  logic signed [MET_W-1:0]  coef [4];
  logic [EXT_W-1:0]         rx;
  logic                     over;
  logic [1:0]               shape_r;
  logic [STEP_W-1:0]        step;
  logic                     run;
  logic [63:0]              p0, p1, p2, prod;
  logic                     prod_neg, prod_hi, prod_vld;
  logic [ACC_W-1:0]         acc;

  logic [STEP_W-1:0]  tsel;
  logic [1:0]         term;
  logic signed [MET_W-1:0] cval;
  logic [31:0]        cmag;
  logic [63:0]        psel;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_out;
  logic               mul_neg;
  logic [ACC_W-1:0]   ext, addend;
  logic               is_ell;

  assign dx  = 33'(qx) - 33'(node.pos_x);
  assign dy  = 33'(qy) - 33'(node.pos_y);
  assign ndx = -dx;
  assign ndy = -dy;
  assign adx = dx[32] ? ndx[31:0] : dx[31:0];
  assign ady = dy[32] ? ndy[31:0] : dy[31:0];

  assign is_ell = (shape_r == SHAPE_ELLIPSE);
  assign tsel   = step - STEP_TERM0;
  assign term   = tsel[2:1];
  assign cval   = coef[term];
  assign cmag   = cval[MET_W-1] ? 32'(-cval) : 32'(cval);

  always_comb begin
    unique case (term)
      2'd0:    psel = p0;
      2'd3:    psel = p2;
      default: psel = p1;
    endcase
  end

  // operand selection per step
  always_comb begin
    mul_a = ax;
    mul_b = ax;
    priority if (step == STEP_SQ0) begin
      mul_a = ax;
      mul_b = ax;
    end else if (step == STEP_SQ1) begin
      mul_a = is_ell ? ax : ay;
      mul_b = ay;
    end else if (step == STEP_SQ2) begin
      mul_a = is_ell ? ay : 32'(rx);
      mul_b = is_ell ? ay : 32'(rx);
    end else begin
      mul_a = cmag;
      mul_b = tsel[0] ? psel[63:32] : psel[31:0];
    end
  end

  assign mul_out = 64'(mul_a) * 64'(mul_b);
  assign mul_neg = cval[MET_W-1] ^ (((term == 2'd1) || (term == 2'd2)) & (sgn_x ^ sgn_y));

  assign ext    = prod_hi ? (ACC_W'(prod) << 32) : ACC_W'(prod);
  assign addend = prod_neg ? -ext : ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      run      <= 1'b0;
      status   <= '0;
      prod_vld <= 1'b0;
      step     <= '0;
    end else begin
      status.done <= 1'b0;
      prod_vld    <= 1'b0;
      if (start) begin
        ax      <= adx;
        ay      <= ady;
        sgn_x   <= dx[32];
        sgn_y   <= dy[32];
        coef[0] <= node.m11;
        coef[1] <= node.m12;
        coef[2] <= node.m21;
        coef[3] <= node.m22;
        rx      <= node.ext_x;
        over    <= adx[31] | ady[31];
        shape_r <= shape;
        step    <= '0;
        acc     <= '0;
        priority case (shape)
          SHAPE_RADIAL, SHAPE_ELLIPSE: begin
            run <= 1'b1;
          end
          SHAPE_BOX: begin
            status.done <= 1'b1;
            status.hit  <= (adx <= 32'(node.ext_x)) && (ady <= 32'(node.ext_y));
          end
          default: begin
            status.done <= 1'b1;
            status.hit  <= 1'b0;
          end
        endcase
      end else if (run) begin
        step <= step + 1'b1;
        if (step == STEP_SQ0) p0 <= mul_out;
        if (step == STEP_SQ1) p1 <= mul_out;
        if (step == STEP_SQ2) p2 <= mul_out;
        if (!is_ell && step == STEP_RAD_OK) begin
          run         <= 1'b0;
          status.done <= 1'b1;
          status.hit  <= !over && (({1'b0, p0} + {1'b0, p1}) < {1'b0, p2});
        end
        if (is_ell && step >= STEP_TERM0 && step <= STEP_TERM7) begin
          prod     <= mul_out;
          prod_neg <= mul_neg;
          prod_hi  <= tsel[0];
          prod_vld <= 1'b1;
        end
        if (is_ell && step == STEP_ELL_OK) begin
          run         <= 1'b0;
          status.done <= 1'b1;
          status.hit  <= $signed(acc) <= $signed(ONE_Q48);
        end
      end
      if (prod_vld) begin
        acc <= acc + addend;
      end
    end
  end

endmodule

@@ design/support_domain_neighbour_search_unit.sv @@
// ----------------------------------------------------------------------------
// support_domain_neighbour_search_unit
// Node table in a RAM, query scans entries in order and reports every node
// whose support holds the query point, last beat marked.
// ----------------------------------------------------------------------------
// load: a new command may follow at once
// query: per scanned node a RAM read, a test start and a wait for the test,
//   radial and elliptical tests sharing one 32x32 multiplier; after the last
//   node a final flush state before the next command
// the receiver cannot stall; a result beat is one cycle, strobed by done
// synchronous reset clears control and registers, node table is undefined
module support_domain_neighbour_search_unit #(
  parameter int MAX_NODES  = 64,
  parameter int COORD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  sdns_pkg::cmd_t                      cmd,
  input  logic                                cfg_we,
  input  logic [sdns_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sdns_pkg::CFG_W-1:0]          cfg_data,
  output logic                                done,
  output sdns_pkg::result_t                   result
);
  import sdns_pkg::*;

  localparam int AW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W = $clog2(MAX_NODES + 1);

  scan_state_t        state, state_next;
  logic [1:0]         shape;
  logic [CFG_W-1:0]   node_count;
  logic [CNT_W-1:0]   scan_n, idx;
  logic signed [31:0] qx, qy;
  logic signed [31:0] px_ext, py_ext;
  logic [IDX_W-1:0]   pend_idx;
  logic               pend_vld;

  logic               wr_en, rd_en, ev_start;
  node_t              wr_node, rd_node;
  logic [$bits(node_t)-1:0] rdata;
  eval_status_t       ev_stat;
  logic               accept, last_node;

  assign px_ext = 32'(signed'(cmd.point_x[COORD_BITS-1:0]));
  assign py_ext = 32'(signed'(cmd.point_y[COORD_BITS-1:0]));

  assign accept = start && !busy;
  assign wr_en  = accept && (cmd.action == ACT_LOAD) &&
                  ({1'b0, cmd.entry_index} < 7'(MAX_NODES));

  always_comb begin
    wr_node.pos_x = px_ext;
    wr_node.pos_y = py_ext;
    wr_node.ext_x = cmd.extent_x;
    wr_node.ext_y = cmd.extent_y;
    wr_node.m11   = cmd.metric_11;
    wr_node.m12   = cmd.metric_12;
    wr_node.m21   = cmd.metric_21;
    wr_node.m22   = cmd.metric_22;
  end

  sdns_ram #(
    .WIDTH ($bits(node_t)),
    .DEPTH (MAX_NODES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (cmd.entry_index[AW-1:0]),
    .wdata (wr_node),
    .re    (rd_en),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  assign rd_node = node_t'(rdata);

  sdns_eval u_eval (
    .clk    (clk),
    .rst    (rst),
    .start  (ev_start),
    .shape  (shape),
    .qx     (qx),
    .qy     (qy),
    .node   (rd_node),
    .status (ev_stat)
  );

  assign busy      = (state != S_IDLE);
  assign last_node = (CNT_W'(idx + 1'b1) == scan_n);

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    ev_start   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start && cmd.action == ACT_QUERY) begin
          state_next = (node_count == '0) ? S_FLUSH : S_READ;
        end
      end
      S_READ: begin
        rd_en      = 1'b1;
        state_next = S_START;
      end
      S_START: begin
        ev_start   = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (ev_stat.done) begin
          state_next = last_node ? S_FLUSH : S_READ;
        end
      end
      S_FLUSH: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      pend_vld   <= 1'b0;
      shape      <= SHAPE_RADIAL;
      node_count <= '0;
      idx        <= '0;
      scan_n     <= '0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SHAPE: shape      <= cfg_data[1:0];
          CFG_COUNT: node_count <= cfg_data;
          default:   ;
        endcase
      end
      if (state == S_IDLE && start && cmd.action == ACT_QUERY) begin
        qx       <= px_ext;
        qy       <= py_ext;
        scan_n   <= (node_count > 7'(MAX_NODES)) ? CNT_W'(MAX_NODES) : CNT_W'(node_count);
        idx      <= '0;
        pend_vld <= 1'b0;
      end
      if (state == S_WAIT && ev_stat.done) begin
        idx <= idx + 1'b1;
        if (ev_stat.hit) begin
          // a held match goes out once a later one shows it is not the last
          if (pend_vld) begin
            done                   <= 1'b1;
            result.neighbour_index <= pend_idx;
            result.found           <= 1'b1;
            result.last            <= 1'b0;
          end
          pend_idx <= IDX_W'(idx);
          pend_vld <= 1'b1;
        end
      end
      if (state == S_FLUSH) begin
        done                   <= 1'b1;
        result.neighbour_index <= pend_vld ? pend_idx : '0;
        result.found           <= pend_vld;
        result.last            <= 1'b1;
      end
    end
  end

  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) != S_IDLE)
    else $error("result beat outside a query");

  a_eval_in_wait: assert property (@(posedge clk) disable iff (rst)
    ev_stat.done |-> state == S_WAIT)
    else $error("node test finished outside wait");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    done && result.last |-> state == S_IDLE)
    else $error("last beat while scan continues");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    done && !result.found |-> result.last)
    else $error("empty beat not marked last");

endmodule
